/* hw/rtl/vgm2o_pkg.sv */
// ============================================================================
// VGM to OPL2 converter package
// Shared types, command codes and divider constants.
// ============================================================================
package vgm2o_pkg;

    // VGM command bytes
    localparam logic [7:0] CMD_WRITE     = 8'h5A;
    localparam logic [7:0] CMD_WAIT      = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
    localparam logic [7:0] CMD_END       = 8'h66;
    localparam logic [3:0] CMD_SHORT_HI  = 4'h7;

    // fixed wait lengths in samples
    localparam logic [15:0] SAMPLES_NTSC = 16'h02DF;
    localparam logic [15:0] SAMPLES_PAL  = 16'h0372;

    // samples per 10 ms code; x/441 == (x*38044)>>24 exactly for any 16-bit x
    localparam logic [15:0] WAIT_DIVISOR = 16'd441;
    localparam logic [31:0] DIV_RECIP    = 32'd38044;
    localparam int          DIV_SHIFT    = 24;

    // header layout
    localparam logic [7:0]  MAGIC_LAST       = 8'd3;
    localparam logic [7:0]  VERSION_FIRST    = 8'd8;
    localparam logic [7:0]  VERSION_LAST     = 8'd11;
    localparam logic [7:0]  HDR_END_SHORT    = 8'd127;
    localparam logic [7:0]  HDR_END_LONG     = 8'd255;
    localparam logic [31:0] VERSION_LONG_HDR = 32'h0000_0161;
    localparam logic [7:0]  LOW_REG_LIMIT    = 8'd4;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_CMD,
        PH_OP1,
        PH_OP2,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        KIND_WRITE       = 3'd0,
        KIND_RUN10       = 3'd1,
        KIND_RUN1        = 3'd2,
        KIND_END         = 3'd3,
        KIND_BAD_MAGIC   = 3'd4,
        KIND_UNSUPPORTED = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_WAIT,
        OP_SHORT,
        OP_END,
        OP_BAD_MAGIC,
        OP_UNSUPPORTED
    } op_code_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] register_number;
        logic [7:0] register_value;
        logic [7:0] repeat_count;
        logic       last;
    } result_t;

    // parsed operation; data is {reg,val}, samples, or remainder increment
    typedef struct packed {
        op_code_t    code;
        logic        clear;
        logic [15:0] data;
    } op_t;

    // one or two results caused by one operation
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } group_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h56;
            2'd1: b = 8'h67;
            2'd2: b = 8'h6D;
            2'd3: b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/vgm_to_opl2_command_converter.sv */
// ============================================================================
// VGM to OPL2 command converter
// Parses a VGM byte stream into OPL2 register writes and wait-code runs.
// ============================================================================
// Path: a register write, end or error result passes the parser input register,
//   the quotient, rest and remainder-loop stages and the output register; a wait
//   also takes 2 steps in the remainder loop. Throughput: 1 byte per cycle while
//   byte_stall is low; a wait with two runs sends both out, the second via the hold slot.
// Reset: rst_n clears all control state; parser starts at header byte zero
//   with a zero time remainder. start_of_file does the same for one byte.
// ============================================================================
module vgm_to_opl2_command_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  vgm2o_pkg::in_item_t byte_data,
    output logic               result_valid,
    input  logic               result_stall,
    output vgm2o_pkg::result_t result_data
);

    // parser -> wait converter: one op per result-producing or
    // remainder-changing byte; bytes with no effect are dropped at the parser
    logic              op_valid;
    logic              op_ready;
    vgm2o_pkg::op_t    op;

    // wait converter -> emitter: groups of one or two results
    logic              grp_valid;
    logic              grp_ready;
    vgm2o_pkg::group_t grp;

    // Input register and header/command state machine. Magic check, version
    // capture and header skip all run here, one byte per cycle unless op_ready holds the parser.
    vgm2o_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    // Divide-by-441 pipeline. The 10 ms count is a reciprocal multiply; the
    // carried remainder loop first registers the sum and quotient, then the new
    // remainder.
    vgm2o_wait u_wait (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    // Output register; a second run result waits in a hold slot.
    vgm2o_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready),
        .grp          (grp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // empty wait runs are never emitted
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == vgm2o_pkg::KIND_RUN10
            || result_data.kind == vgm2o_pkg::KIND_RUN1)
        |-> result_data.repeat_count != 8'd0)
        else $error("wait run with zero count");

    // writes to the low registers are dropped
    a_low_reg_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == vgm2o_pkg::KIND_WRITE
        |-> result_data.register_number > vgm2o_pkg::LOW_REG_LIMIT)
        else $error("low register write emitted");

    // only a 10 ms run can be followed by another result of the same byte
    a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.last
        |-> result_data.kind == vgm2o_pkg::KIND_RUN10)
        else $error("non-final result is not a 10 ms run");

    // the 1 ms run of a pair follows directly
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_data.last
        |=> result_valid && result_data.kind == vgm2o_pkg::KIND_RUN1
            && result_data.last)
        else $error("second run of a pair missing");

endmodule

/* hw/rtl/vgm2o_parser.sv */
// ============================================================================
// VGM byte parser
// Input register plus header/command decoder; forwards operations in order.
// ============================================================================
module vgm2o_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  vgm2o_pkg::in_item_t byte_data,
    output logic                op_valid,
    input  logic                op_ready,
    output vgm2o_pkg::op_t      op
);

    logic                in_valid_reg;
    vgm2o_pkg::in_item_t in_reg;

    vgm2o_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [7:0]        pos_reg, pos_next, pos_eff;
    logic [31:0]       ver_reg, ver_next, ver_eff;
    logic              good_reg, good_next, good_eff;
    logic              cmdw_reg, cmdw_next, cmdw_eff;
    logic [7:0]        opnd_reg, opnd_next, opnd_eff;
    logic              clr_reg;

    logic [7:0]  b;
    logic        sof;
    logic        magic_bad;
    logic        op_needed;
    logic        in_take;
    logic [15:0] short_n;
    logic [15:0] short_inc;

    assign b   = in_reg.stream_byte;
    assign sof = in_reg.start_of_file;

    // start_of_file restarts the parser before the byte is decoded
    always_comb
    begin
        if (sof)
        begin
            phase_eff = vgm2o_pkg::PH_MAGIC;
            pos_eff   = '0;
            ver_eff   = '0;
            good_eff  = 1'b1;
            cmdw_eff  = 1'b0;
            opnd_eff  = '0;
        end
        else
        begin
            phase_eff = phase_reg;
            pos_eff   = pos_reg;
            ver_eff   = ver_reg;
            good_eff  = good_reg;
            cmdw_eff  = cmdw_reg;
            opnd_eff  = opnd_reg;
        end
    end

    assign magic_bad = !good_eff || (b != vgm2o_pkg::magic_byte(pos_eff[1:0]));
    assign short_n   = 16'(b[3:0]) + 16'd1;
    assign short_inc = (short_n << 3) + (short_n << 1);

    // next state
    always_comb
    begin
        phase_next = phase_eff;
        pos_next   = pos_eff;
        ver_next   = ver_eff;
        good_next  = good_eff;
        cmdw_next  = cmdw_eff;
        opnd_next  = opnd_eff;
        unique case (phase_eff)
            vgm2o_pkg::PH_MAGIC:
            begin
                good_next = !magic_bad;
                if (pos_eff >= vgm2o_pkg::MAGIC_LAST)
                    phase_next = magic_bad ? vgm2o_pkg::PH_HALT : vgm2o_pkg::PH_HEADER;
                pos_next = pos_eff + 8'd1;
            end
            vgm2o_pkg::PH_HEADER:
            begin
                if (pos_eff >= vgm2o_pkg::VERSION_FIRST && pos_eff <= vgm2o_pkg::VERSION_LAST)
                    ver_next = ver_eff | (32'(b) << {pos_eff[1:0], 3'b000});
                if ((pos_eff == vgm2o_pkg::HDR_END_SHORT
                        && ver_eff < vgm2o_pkg::VERSION_LONG_HDR)
                        || pos_eff == vgm2o_pkg::HDR_END_LONG)
                    phase_next = vgm2o_pkg::PH_CMD;
                pos_next = pos_eff + 8'd1;
            end
            vgm2o_pkg::PH_CMD:
            begin
                priority if (b == vgm2o_pkg::CMD_WRITE || b == vgm2o_pkg::CMD_WAIT)
                begin
                    cmdw_next  = (b == vgm2o_pkg::CMD_WRITE);
                    phase_next = vgm2o_pkg::PH_OP1;
                end
                else if (b == vgm2o_pkg::CMD_WAIT_NTSC || b == vgm2o_pkg::CMD_WAIT_PAL
                        || b[7:4] == vgm2o_pkg::CMD_SHORT_HI)
                    phase_next = vgm2o_pkg::PH_CMD;
                else
                    phase_next = vgm2o_pkg::PH_HALT;
            end
            vgm2o_pkg::PH_OP1:
            begin
                opnd_next  = b;
                phase_next = vgm2o_pkg::PH_OP2;
            end
            vgm2o_pkg::PH_OP2:
                phase_next = vgm2o_pkg::PH_CMD;
            default:
                phase_next = vgm2o_pkg::PH_HALT;
        endcase
    end

    // operation output
    always_comb
    begin
        op_needed  = 1'b0;
        op.code    = vgm2o_pkg::OP_WRITE;
        op.data    = '0;
        // a restart clears the time remainder ahead of the next operation
        op.clear   = clr_reg || sof;
        unique case (phase_eff)
            vgm2o_pkg::PH_MAGIC:
            begin
                op_needed = (pos_eff >= vgm2o_pkg::MAGIC_LAST) && magic_bad;
                op.code   = vgm2o_pkg::OP_BAD_MAGIC;
            end
            vgm2o_pkg::PH_CMD:
            begin
                op_needed = 1'b1;
                priority if (b == vgm2o_pkg::CMD_WRITE || b == vgm2o_pkg::CMD_WAIT)
                    op_needed = 1'b0;
                else if (b == vgm2o_pkg::CMD_WAIT_NTSC)
                begin
                    op.code = vgm2o_pkg::OP_WAIT;
                    op.data = vgm2o_pkg::SAMPLES_NTSC;
                end
                else if (b == vgm2o_pkg::CMD_WAIT_PAL)
                begin
                    op.code = vgm2o_pkg::OP_WAIT;
                    op.data = vgm2o_pkg::SAMPLES_PAL;
                end
                else if (b == vgm2o_pkg::CMD_END)
                    op.code = vgm2o_pkg::OP_END;
                else if (b[7:4] == vgm2o_pkg::CMD_SHORT_HI)
                begin
                    op.code = vgm2o_pkg::OP_SHORT;
                    op.data = short_inc;
                end
                else
                    op.code = vgm2o_pkg::OP_UNSUPPORTED;
            end
            vgm2o_pkg::PH_OP2:
            begin
                if (cmdw_eff)
                begin
                    op_needed = opnd_eff > vgm2o_pkg::LOW_REG_LIMIT;
                    op.code   = vgm2o_pkg::OP_WRITE;
                    op.data   = {opnd_eff, b};
                end
                else
                begin
                    op_needed = 1'b1;
                    op.code   = vgm2o_pkg::OP_WAIT;
                    op.data   = {b, opnd_eff};
                end
            end
            default:
                op_needed = 1'b0;
        endcase
    end

    assign op_valid   = in_valid_reg && op_needed;
    assign in_take    = in_valid_reg && (!op_needed || op_ready);
    assign byte_stall = in_valid_reg && !in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= vgm2o_pkg::PH_MAGIC;
            pos_reg      <= '0;
            ver_reg      <= '0;
            good_reg     <= 1'b1;
            cmdw_reg     <= 1'b0;
            opnd_reg     <= '0;
            clr_reg      <= 1'b0;
        end
        else
        begin
            if (!byte_stall)
                in_valid_reg <= byte_valid;
            if (in_take)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                ver_reg   <= ver_next;
                good_reg  <= good_next;
                cmdw_reg  <= cmdw_next;
                opnd_reg  <= opnd_next;
                if (op_needed)
                    clr_reg <= 1'b0;
                else if (sof)
                    clr_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
            in_reg <= byte_data;
    end

endmodule

/* hw/rtl/vgm2o_wait.sv */
// ============================================================================
// VGM wait converter
// Three-stage pipe: 10 ms quotient, scaled rest, then the remainder loop.
// ============================================================================
module vgm2o_wait (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  vgm2o_pkg::op_t   op,
    output logic             grp_valid,
    input  logic             grp_ready,
    output vgm2o_pkg::group_t grp
);

    // stage 1: samples / 441
    logic               s1_valid_reg;
    vgm2o_pkg::op_t     s1_op_reg;
    logic [31:0]        s1_prod;
    logic [7:0]         s1_c10;
    logic               s1_ready;

    // stage 2: rest * 10
    logic               s2_valid_reg;
    vgm2o_pkg::op_t     s2_op_reg;
    logic [7:0]         s2_c10_reg;
    logic [15:0]        s2_c10x;
    logic [8:0]         s2_rest;
    logic [15:0]        s2_rest16;
    logic [15:0]        s2_arg;
    vgm2o_pkg::op_t     s2_fwd;
    logic               s2_ready;

    // stage 3: remainder loop, two steps for a wait
    logic               s3_valid_reg;
    vgm2o_pkg::op_t     s3_op_reg;
    logic [7:0]         s3_c10_reg;
    logic               s3_step_reg;
    logic [15:0]        sum_reg;
    logic [7:0]         q_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        rem_eff;
    logic [15:0]        s3_sum;
    logic [31:0]        s3_prod;
    logic [15:0]        rem_new;
    logic               s3_is_wait;
    logic               s3_is_short;
    logic               s3_done;
    logic               s3_ready;

    assign s1_prod  = 32'(s1_op_reg.data) * vgm2o_pkg::DIV_RECIP;
    assign s1_c10   = s1_prod[vgm2o_pkg::DIV_SHIFT +: 8];
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign op_ready = s1_ready;

    assign s2_c10x   = 16'(s2_c10_reg) * vgm2o_pkg::WAIT_DIVISOR;
    assign s2_rest   = 9'(s2_op_reg.data - s2_c10x);
    assign s2_rest16 = 16'(s2_rest);
    assign s2_arg    = (s2_op_reg.code == vgm2o_pkg::OP_WAIT)
                     ? (s2_rest16 << 3) + (s2_rest16 << 1)
                     : s2_op_reg.data;
    assign s2_ready  = !s2_valid_reg || s3_ready;

    // stage 2 operation with its data replaced by the stage 3 argument
    always_comb
    begin
        s2_fwd      = s2_op_reg;
        s2_fwd.data = s2_arg;
    end

    assign s3_is_wait  = (s3_op_reg.code == vgm2o_pkg::OP_WAIT);
    assign s3_is_short = (s3_op_reg.code == vgm2o_pkg::OP_SHORT);
    assign rem_eff     = s3_op_reg.clear ? 16'd0 : rem_reg;
    assign s3_sum      = rem_eff + s3_op_reg.data;
    assign s3_prod     = 32'(s3_sum) * vgm2o_pkg::DIV_RECIP;
    assign rem_new     = sum_reg - 16'(q_reg) * vgm2o_pkg::WAIT_DIVISOR;

    always_comb
    begin
        grp_valid                  = 1'b0;
        grp.two                    = 1'b0;
        grp.first.kind             = vgm2o_pkg::KIND_WRITE;
        grp.first.register_number  = '0;
        grp.first.register_value   = '0;
        grp.first.repeat_count     = '0;
        grp.first.last             = 1'b1;
        grp.second.kind            = vgm2o_pkg::KIND_RUN1;
        grp.second.register_number = '0;
        grp.second.register_value  = '0;
        grp.second.repeat_count    = q_reg;
        grp.second.last            = 1'b1;
        unique case (s3_op_reg.code)
            vgm2o_pkg::OP_WRITE:
            begin
                grp_valid                 = s3_valid_reg;
                grp.first.register_number = s3_op_reg.data[15:8];
                grp.first.register_value  = s3_op_reg.data[7:0];
            end
            vgm2o_pkg::OP_WAIT:
            begin
                // empty runs are skipped
                grp_valid = s3_valid_reg && s3_step_reg
                          && (s3_c10_reg != 8'd0 || q_reg != 8'd0);
                grp.two   = (s3_c10_reg != 8'd0) && (q_reg != 8'd0);
                if (s3_c10_reg != 8'd0)
                begin
                    grp.first.kind         = vgm2o_pkg::KIND_RUN10;
                    grp.first.repeat_count = s3_c10_reg;
                    grp.first.last         = (q_reg == 8'd0);
                end
                else
                begin
                    grp.first.kind         = vgm2o_pkg::KIND_RUN1;
                    grp.first.repeat_count = q_reg;
                end
            end
            vgm2o_pkg::OP_END:
            begin
                grp_valid      = s3_valid_reg;
                grp.first.kind = vgm2o_pkg::KIND_END;
            end
            vgm2o_pkg::OP_BAD_MAGIC:
            begin
                grp_valid      = s3_valid_reg;
                grp.first.kind = vgm2o_pkg::KIND_BAD_MAGIC;
            end
            vgm2o_pkg::OP_UNSUPPORTED:
            begin
                grp_valid      = s3_valid_reg;
                grp.first.kind = vgm2o_pkg::KIND_UNSUPPORTED;
            end
            default:
                grp_valid = 1'b0;
        endcase
    end

    assign s3_done  = s3_valid_reg && (!s3_is_wait || s3_step_reg)
                    && (!grp_valid || grp_ready);
    assign s3_ready = !s3_valid_reg || s3_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_step_reg  <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= op_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg && s3_is_wait && !s3_step_reg)
                s3_step_reg <= 1'b1;
            else if (s3_done)
                s3_step_reg <= 1'b0;
            if (s3_done && s3_is_wait)
                rem_reg <= rem_new;
            else if (s3_done && s3_is_short)
                rem_reg <= s3_sum;
            else if (s3_done && s3_op_reg.clear)
                rem_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && op_valid)
            s1_op_reg <= op;
        if (s2_ready && s1_valid_reg)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_c10_reg <= s1_c10;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_op_reg  <= s2_fwd;
            s3_c10_reg <= s2_c10_reg;
        end
        if (s3_valid_reg && s3_is_wait && !s3_step_reg)
        begin
            sum_reg <= s3_sum;
            q_reg   <= s3_prod[vgm2o_pkg::DIV_SHIFT +: 8];
        end
    end

endmodule

/* hw/rtl/vgm2o_emit.sv */
// ============================================================================
// VGM result emitter
// Output register with a hold slot for the second result of a group.
// ============================================================================
module vgm2o_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_valid,
    output logic               grp_ready,
    input  vgm2o_pkg::group_t  grp,
    output logic               result_valid,
    input  logic               result_stall,
    output vgm2o_pkg::result_t result_data
);

    logic               out_valid_reg;
    vgm2o_pkg::result_t out_reg;
    logic               second_valid_reg;
    vgm2o_pkg::result_t second_reg;
    logic               out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign grp_ready    = !second_valid_reg && out_free;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (second_valid_reg)
            begin
                out_valid_reg    <= 1'b1;
                second_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg    <= grp_valid;
                second_valid_reg <= grp_valid && grp.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (second_valid_reg)
                out_reg <= second_reg;
            else if (grp_valid)
            begin
                out_reg    <= grp.first;
                second_reg <= grp.second;
            end
        end
    end

endmodule
